@@ rtl/tce_pkg.sv @@
// shared constants, codes and types of the text console engine
package tce_pkg;

  // fixed field widths
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;

  // default geometry
  localparam int DEF_WIDTH  = 80;
  localparam int DEF_HEIGHT = 25;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd3;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam int TAB_STOP = 8;
  localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(TAB_STOP - 1));

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] INIT_CELL  = {ATTR_RESET, CH_SPACE};

  // config register index
  localparam logic CFG_IDX_ATTR = 1'b0;

  // outcome of one put-char step
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] wr_col;
    logic             wr_en;
    logic             wr_blank;
    logic             scroll;
  } step_t;

endpackage

@@ rtl/tce_step.sv @@
// cursor update and cell write decision for one put-char word
module tce_step #(
  parameter int WIDTH  = tce_pkg::DEF_WIDTH,
  parameter int HEIGHT = tce_pkg::DEF_HEIGHT
) (
  input  logic [tce_pkg::COL_W-1:0]  col,
  input  logic [tce_pkg::ROW_W-1:0]  row,
  input  logic [tce_pkg::CHAR_W-1:0] ch,
  output tce_pkg::step_t             step
);
  import tce_pkg::*;

  logic [COL_W:0] c_nxt;
  logic [ROW_W:0] r_nxt;

  always_comb begin
    c_nxt         = {1'b0, col};
    r_nxt         = {1'b0, row};
    step          = '0;
    step.wr_col   = col;
    unique case (ch)
      CH_BS: begin
        // only steps back when not at the left edge
        if (col != '0) begin
          step.wr_col   = col - COL_W'(1);
          step.wr_en    = 1'b1;
          step.wr_blank = 1'b1;
          c_nxt         = c_nxt - (COL_W+1)'(1);
        end
      end
      CH_LF: begin
        c_nxt = '0;
        r_nxt = r_nxt + (ROW_W+1)'(1);
      end
      CH_CR:  c_nxt = '0;
      CH_TAB: c_nxt = (c_nxt + (COL_W+1)'(TAB_STOP)) & TAB_MASK;
      default: begin
        step.wr_en = 1'b1;
        c_nxt      = c_nxt + (COL_W+1)'(1);
      end
    endcase
    // wrap at the right edge
    if (c_nxt >= (COL_W+1)'(WIDTH)) begin
      c_nxt = '0;
      r_nxt = r_nxt + (ROW_W+1)'(1);
    end
    // off the bottom
    if (r_nxt >= (ROW_W+1)'(HEIGHT)) begin
      step.scroll = 1'b1;
      r_nxt       = (ROW_W+1)'(HEIGHT - 1);
    end
    step.col = c_nxt[COL_W-1:0];
    step.row = r_nxt[ROW_W-1:0];
  end

endmodule

@@ rtl/text_console_engine.sv @@
// top level of the text console engine: cell store, cursor and sequencer
//
// Text console with a WIDTH x HEIGHT store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a cursor. A word is taken when
// start is high and busy is low; each word gives exactly one result, shown on
// the out_ ports for the single cycle in which out_strobe is high. The
// receiver cannot hold results off, so they must be captured on that cycle.
// Put-char without scroll, set cursor and read cell go from the accepting
// edge through S_EXEC to the strobe cycle, and the next word can be taken
// during the strobe cycle. A put-char that scrolls then copies the screen
// up one row through the single memory port pair, moving each cell with a
// read one row down in S_SCR_RD and then a write in S_SCR_WR, and then
// blanks the bottom row one cell per cycle. Clear writes one cell per cycle.
// After reset the block runs a clearing pass that fills the store with
// 0x0720 while busy is high; attribute writes over the APB port are taken
// at any time and read back on prdata.
module text_console_engine #(
  parameter int WIDTH  = tce_pkg::DEF_WIDTH,
  parameter int HEIGHT = tce_pkg::DEF_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [tce_pkg::FUNC_W-1:0]  in_func,
  input  logic [tce_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tce_pkg::COL_W-1:0]   in_new_col,
  input  logic [tce_pkg::ROW_W-1:0]   in_new_row,
  input  logic [tce_pkg::IDX_W-1:0]   in_cell_index,
  // result channel
  output logic                        out_strobe,
  output logic [tce_pkg::COL_W-1:0]   out_cursor_col,
  output logic [tce_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tce_pkg::POS_W-1:0]   out_cursor_pos,
  output logic [tce_pkg::CELL_W-1:0]  out_cell_data,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tce_pkg::*;

  localparam int CELLS     = WIDTH * HEIGHT;
  localparam int ADDR_W    = $clog2(CELLS);
  // one spare bit so the cell count itself fits for the range compare
  localparam int EXT_W     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int LAST_COPY = WIDTH * (HEIGHT - 1) - 1;

  // sequencer states
  localparam logic [2:0] S_INIT   = 3'd0;  // clearing pass after reset
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCR_RD = 3'd3;
  localparam logic [2:0] S_SCR_WR = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              strobe_r, strobe_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;

  // captured command word
  logic [FUNC_W-1:0] func_r;
  logic [CHAR_W-1:0] ch_r;
  logic [COL_W-1:0]  nc_r;
  logic [ROW_W-1:0]  nr_r;
  logic              in_range_r;

  // cell store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [CELL_W-1:0] wd;
  logic [ADDR_W-1:0] ra;

  logic              accept;
  logic              cfg_wr;
  logic [EXT_W-1:0]  idx_ext;
  logic [ADDR_W-1:0] ptr_sum;
  logic [COL_W-1:0]  lin_col;
  logic [ADDR_W-1:0] lin;
  logic [EXT_W-1:0]  lin_ext;
  logic [CELL_W-1:0] blank;
  step_t             step;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // config port, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == CFG_IDX_ATTR) ? {24'b0, attr_r} : 32'b0;

  assign idx_ext = EXT_W'(in_cell_index);

  // shared pointer adder: next cell, or the source one row down when scrolling
  assign ptr_sum = ptr_r + ((state_r == S_SCR_RD) ? ADDR_W'(WIDTH) : ADDR_W'(1));

  // linear cell position: write address during exec, cursor position otherwise
  assign lin_col = (state_r == S_EXEC) ? step.wr_col : col_r;
  assign lin     = ADDR_W'(row_r) * ADDR_W'(WIDTH) + ADDR_W'(lin_col);
  assign lin_ext = EXT_W'(lin);

  assign blank = {attr_r, CH_SPACE};

  tce_step #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_step (
    .col  (col_r),
    .row  (row_r),
    .ch   (ch_r),
    .step (step)
  );

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    attr_nxt   = attr_r;
    strobe_nxt = 1'b0;
    data_nxt   = data_r;
    we         = 1'b0;
    wa         = ptr_r;
    wd         = blank;
    ra         = idx_ext[ADDR_W-1:0];

    if (cfg_wr && (paddr[2] == CFG_IDX_ATTR)) begin
      attr_nxt = pwdata[ATTR_W-1:0];
    end

    unique case (state_r)
      S_INIT: begin
        // fixed reset pattern, independent of the attribute register
        we = 1'b1;
        wd = INIT_CELL;
        if (ptr_r == ADDR_W'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_sum;
        end
      end
      S_IDLE: begin
        // read port follows in_cell_index, so the cell read at the accepting edge is in rdata_r in S_EXEC
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        data_nxt = '0;
        unique case (func_r)
          FUNC_PUT: begin
            we      = step.wr_en;
            wa      = lin;
            wd      = step.wr_blank ? blank : {attr_r, ch_r};
            col_nxt = step.col;
            row_nxt = step.row;
            if (step.scroll) begin
              ptr_nxt   = '0;
              state_nxt = S_SCR_RD;
            end else begin
              strobe_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          FUNC_CLR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            ptr_nxt   = '0;
            state_nxt = S_FILL;
          end
          FUNC_SET: begin
            col_nxt    = ({1'b0, nc_r} >= (COL_W+1)'(WIDTH)) ? COL_W'(WIDTH - 1) : nc_r;
            row_nxt    = ({1'b0, nr_r} >= (ROW_W+1)'(HEIGHT)) ? ROW_W'(HEIGHT - 1) : nr_r;
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
          FUNC_READ: begin
            data_nxt   = in_range_r ? rdata_r : '0;
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCR_RD: begin
        ra        = ptr_sum;
        state_nxt = S_SCR_WR;
      end
      S_SCR_WR: begin
        we = 1'b1;
        wd = rdata_r;
        if (ptr_r == ADDR_W'(LAST_COPY)) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_SCR_RD;
        end
        ptr_nxt = ptr_sum;
      end
      S_FILL: begin
        we = 1'b1;
        if (ptr_r == ADDR_W'(CELLS - 1)) begin
          ptr_nxt    = '0;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          ptr_nxt = ptr_sum;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      ptr_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      attr_r   <= ATTR_RESET;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      attr_r   <= attr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (accept) begin
      func_r     <= in_func;
      ch_r       <= in_char_code;
      nc_r       <= in_new_col;
      nr_r       <= in_new_row;
      in_range_r <= (idx_ext < EXT_W'(CELLS));
    end
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  // cursor fields hold steady through the strobe cycle
  assign out_strobe     = strobe_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;
  assign out_cursor_pos = lin_ext[POS_W-1:0];
  assign out_cell_data  = data_r;

endmodule

@@ rtl/tce_checker.sv @@
// port-level checks of the text console engine, bound to the top level
module tce_checker #(
  parameter int WIDTH  = tce_pkg::DEF_WIDTH,
  parameter int HEIGHT = tce_pkg::DEF_HEIGHT
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input logic [tce_pkg::COL_W-1:0]  out_cursor_col,
  input logic [tce_pkg::ROW_W-1:0]  out_cursor_row,
  input logic [tce_pkg::POS_W-1:0]  out_cursor_pos
);
  import tce_pkg::*;

  localparam int LIN_W = COL_W + ROW_W + 1;

  logic [LIN_W-1:0] lin_chk;
  assign lin_chk = LIN_W'(out_cursor_row) * LIN_W'(WIDTH) + LIN_W'(out_cursor_col);

  // accepted word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // results come out only while the block is ready again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // one word per result: strobes never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // cursor inside the screen, compared one bit wider so full-size geometry fits
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (({1'b0, out_cursor_col} < (COL_W+1)'(WIDTH)) &&
                    ({1'b0, out_cursor_row} < (ROW_W+1)'(HEIGHT))))
    else $error("cursor outside the screen");

  // linear position matches column and row
  a_cursor_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_cursor_pos == lin_chk[POS_W-1:0]))
    else $error("cursor position does not match column and row");

endmodule

bind text_console_engine tce_checker #(
  .WIDTH  (WIDTH),
  .HEIGHT (HEIGHT)
) u_tce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row),
  .out_cursor_pos (out_cursor_pos)
);
